// ===== rtl/core/sfb_pkg.sv =====
// Shared types and constants for the serial frame builder.
`timescale 1ns / 1ps

package sfb_pkg;

  localparam int OverheadBytes = 12;
  localparam int TotalW = 9;
  localparam int StepW = 4;

  // input opcode
  typedef enum logic {
    OP_BEGIN   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_REJECT,
    KIND_BEGIN,
    KIND_DATA
  } kind_t;

  // one queued command for the byte sequencer
  typedef struct packed {
    kind_t              kind;
    logic               is_end;   // empty frame or final payload byte: checksum follows
    logic [31:0]        ident;
    logic [TotalW-1:0]  total;
    logic [7:0]         data;
  } cmd_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'h48;
      2'd1: b = 8'h43;
      2'd2: b = 8'h5A;
      2'd3: b = 8'h4E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/sfb_front.sv =====
// Input side: accepts items, tracks the open frame and classifies each transaction.
`timescale 1ns / 1ps

module sfb_front #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic               opcode,
  input  logic [31:0]        frame_ident,
  input  logic [7:0]         payload_count,
  input  logic [7:0]         payload_byte,
  output logic               enq,
  output sfb_pkg::cmd_t      enq_cmd
);

  localparam logic [sfb_pkg::TotalW-1:0] MaxTotal = sfb_pkg::TotalW'(MAX_FRAME_BYTES);
  localparam logic [sfb_pkg::TotalW-1:0] Overhead = sfb_pkg::TotalW'(sfb_pkg::OverheadBytes);

  logic                        frame_open;
  logic [7:0]                  bytes_left;
  logic                        accept;
  logic [sfb_pkg::TotalW-1:0]  total;
  logic                        reject;

  assign accept = push && !full;
  assign total  = {1'b0, payload_count} + Overhead;
  assign reject = total > MaxTotal;

  always_comb begin
    enq_cmd.ident = frame_ident;
    enq_cmd.total = total;
    enq_cmd.data  = payload_byte;
    if (opcode == sfb_pkg::OP_BEGIN) begin
      enq_cmd.kind   = reject ? sfb_pkg::KIND_REJECT : sfb_pkg::KIND_BEGIN;
      enq_cmd.is_end = payload_count == 8'd0;
      enq            = accept;
    end else begin
      enq_cmd.kind   = sfb_pkg::KIND_DATA;
      enq_cmd.is_end = bytes_left == 8'd1;
      enq            = accept && frame_open;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= 8'd0;
    end else if (accept) begin
      if (opcode == sfb_pkg::OP_BEGIN) begin
        if (!reject) begin
          frame_open <= payload_count != 8'd0;
          bytes_left <= payload_count;
        end
      end else if (frame_open) begin
        bytes_left <= bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          frame_open <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sfb_queue.sv =====
// Command queue between the front and the byte sequencer.
`timescale 1ns / 1ps

module sfb_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           enq,
  input  sfb_pkg::cmd_t  enq_cmd,
  output logic           full,
  input  logic           deq,
  output logic           head_valid,
  output sfb_pkg::cmd_t  head_cmd
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  sfb_pkg::cmd_t    mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_enq;
  logic             do_deq;

  assign full       = count == DepthCnt;
  assign head_valid = count != '0;
  assign head_cmd   = mem[rd_ptr];
  assign do_enq     = enq && !full;
  assign do_deq     = deq && head_valid;

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[wr_ptr] <= enq_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_deq) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_enq && !do_deq) begin
        count <= count + 1'b1;
      end else if (do_deq && !do_enq) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DepthCnt)
    else $error("queue count beyond depth");
  a_no_deq_empty: assert property (@(posedge clk) disable iff (rst) deq |-> head_valid)
    else $error("dequeue from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
      (count == '0 || count == DepthCnt) |-> wr_ptr == rd_ptr)
    else $error("pointers disagree with count");

endmodule

// ===== rtl/core/sfb_back.sv =====
// Byte sequencer: expands queued commands into frame bytes and keeps the checksum.
`timescale 1ns / 1ps

module sfb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  sfb_pkg::cmd_t  head_cmd,
  output logic           deq,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           frame_done,
  output logic           too_long,
  output logic           run_last
);

  localparam logic [sfb_pkg::StepW-1:0] StepLenLo = 4'd4;
  localparam logic [sfb_pkg::StepW-1:0] StepLenHi = 4'd5;
  localparam logic [sfb_pkg::StepW-1:0] StepId0   = 4'd6;
  localparam logic [sfb_pkg::StepW-1:0] StepId1   = 4'd7;
  localparam logic [sfb_pkg::StepW-1:0] StepId2   = 4'd8;
  localparam logic [sfb_pkg::StepW-1:0] StepId3   = 4'd9;
  localparam logic [sfb_pkg::StepW-1:0] StepCkLo  = 4'd10;
  localparam logic [sfb_pkg::StepW-1:0] StepCkHi  = 4'd11;

  logic [sfb_pkg::StepW-1:0]  step;
  logic [sfb_pkg::StepW-1:0]  step_next;
  logic [15:0]                sum;
  logic [15:0]                sum_next;
  logic                       out_valid;
  logic                       advance;
  logic                       adds;
  logic                       finish;
  logic [7:0]                 byte_sel;
  logic                       done_sel;
  logic                       err_sel;
  logic                       last_sel;

  assign advance = head_valid && (!out_valid || pop);
  assign deq     = advance && finish;
  assign empty   = !out_valid;

  always_comb begin
    byte_sel  = 8'd0;
    done_sel  = 1'b0;
    err_sel   = 1'b0;
    last_sel  = 1'b0;
    adds      = 1'b0;
    finish    = 1'b0;
    step_next = step + 1'b1;
    if (step == StepCkLo) begin
      byte_sel  = sum[7:0];
      step_next = StepCkHi;
    end else if (step == StepCkHi) begin
      byte_sel  = sum[15:8];
      done_sel  = 1'b1;
      last_sel  = 1'b1;
      finish    = 1'b1;
      step_next = '0;
    end else begin
      case (head_cmd.kind)
        sfb_pkg::KIND_BEGIN: begin
          adds = 1'b1;
          case (step)
            StepLenLo: byte_sel = head_cmd.total[7:0];
            StepLenHi: byte_sel = 8'(head_cmd.total[sfb_pkg::TotalW-1:8]);
            StepId0:   byte_sel = head_cmd.ident[7:0];
            StepId1:   byte_sel = head_cmd.ident[15:8];
            StepId2:   byte_sel = head_cmd.ident[23:16];
            StepId3:   byte_sel = head_cmd.ident[31:24];
            default:   byte_sel = sfb_pkg::hdr_byte(step[1:0]);
          endcase
          if (step == StepId3) begin
            if (head_cmd.is_end) begin
              step_next = StepCkLo;
            end else begin
              last_sel  = 1'b1;
              finish    = 1'b1;
              step_next = '0;
            end
          end
        end
        sfb_pkg::KIND_DATA: begin
          adds     = 1'b1;
          byte_sel = head_cmd.data;
          if (head_cmd.is_end) begin
            step_next = StepCkLo;
          end else begin
            last_sel  = 1'b1;
            finish    = 1'b1;
            step_next = '0;
          end
        end
        default: begin
          err_sel   = 1'b1;
          last_sel  = 1'b1;
          finish    = 1'b1;
          step_next = '0;
        end
      endcase
    end
  end

  // a frame's sum restarts on its first header byte
  assign sum_next = (head_cmd.kind == sfb_pkg::KIND_BEGIN && step == '0) ?
                    {8'd0, byte_sel} : sum + {8'd0, byte_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        step      <= step_next;
        out_valid <= 1'b1;
        if (adds) begin
          sum <= sum_next;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= byte_sel;
      frame_done <= done_sel;
      too_long   <= err_sel;
      run_last   <= last_sel;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst) step <= StepCkHi)
    else $error("sequencer step out of range");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
      (out_valid && frame_done) |-> (run_last && !too_long))
    else $error("checksum end not marked last");
  a_err_form: assert property (@(posedge clk) disable iff (rst)
      (out_valid && too_long) |-> (run_last && out_byte == 8'd0))
    else $error("malformed error result");
  a_ck_follow: assert property (@(posedge clk) disable iff (rst)
      (advance && step == StepCkLo) |=> step == StepCkHi)
    else $error("checksum bytes split");

endmodule

// ===== rtl/core/serial_frame_builder.sv =====
// Serial frame builder top level: A begin transaction either yields one error
// result (12 plus the length over MAX_FRAME_BYTES) or opens a frame and emits
// the 4-byte header, the little-endian 16-bit frame length and the 32-bit
// identifier; each payload transaction passes its byte, and the frame's last
// byte (or an empty begin) is followed by the 16-bit additive checksum, low byte
// first. Payload with no frame open is taken and dropped. Input is taken at one
// transaction per cycle while the QUEUE_DEPTH-entry command queue has room; the
// byte sequencer behind it puts out one result byte per cycle while its output
// register is free or popped; a payload yields one byte, a begin ten (twelve
// if empty), a frame's last byte three. Results leave via a one-entry output register.
`timescale 1ns / 1ps

module serial_frame_builder #(
  parameter int MAX_FRAME_BYTES = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [31:0] frame_ident,
  input  logic [7:0]  payload_count,
  input  logic [7:0]  payload_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        frame_done,
  output logic        too_long,
  output logic        run_last
);

  logic           enq;
  sfb_pkg::cmd_t  enq_cmd;
  logic           deq;
  logic           head_valid;
  sfb_pkg::cmd_t  head_cmd;

  sfb_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .opcode(opcode),
    .frame_ident(frame_ident),
    .payload_count(payload_count),
    .payload_byte(payload_byte),
    .enq(enq),
    .enq_cmd(enq_cmd)
  );

  sfb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .enq(enq),
    .enq_cmd(enq_cmd),
    .full(full),
    .deq(deq),
    .head_valid(head_valid),
    .head_cmd(head_cmd)
  );

  sfb_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head_cmd(head_cmd),
    .deq(deq),
    .pop(pop),
    .empty(empty),
    .out_byte(out_byte),
    .frame_done(frame_done),
    .too_long(too_long),
    .run_last(run_last)
  );

endmodule

// ===== test/serial_frame_builder_tb.sv =====
// Self-checking testbench for serial_frame_builder: predicts every frame byte and checks it in order.
`timescale 1ns / 1ps

module serial_frame_builder_tb;

  localparam int FrameLimit = 64;
  localparam int MaxPayload = FrameLimit - sfb_pkg::OverheadBytes;
  localparam logic [31:0] HdrSeq = 32'h4E5A4348;  // header bytes, first byte in the low lane
  localparam int ItemTarget = 450;
  localparam int QuietFrom = 390;
  localparam int PauseAt = 200;
  localparam int LongHold = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       done;
    logic       err;
    logic       last;
  } wire_byte_t;

  class frame_byte_tracker;
    wire_byte_t bytes_due[$];
    bit         frame_open;
    bit [7:0]   bytes_left;
    bit [15:0]  running_sum;
    int         accepted, frames, rejects, drops, abandons;
    int         checked, mismatches;

    function void add_data(logic [7:0] b, logic last);
      running_sum += b;
      bytes_due.push_back('{data: b, done: 1'b0, err: 1'b0, last: last});
    endfunction

    function void add_checksum();
      bytes_due.push_back('{data: running_sum[7:0], done: 1'b0, err: 1'b0, last: 1'b0});
      bytes_due.push_back('{data: running_sum[15:8], done: 1'b1, err: 1'b0, last: 1'b1});
      frame_open = 1'b0;
      bytes_left = '0;
      frames++;
    endfunction

    // Predict the result bytes of one accepted transaction; returns how many.
    function int take_item(sfb_pkg::op_t op, logic [31:0] ident, logic [7:0] count,
                           logic [7:0] pbyte);
      int unsigned total;
      int          size_at_entry;
      size_at_entry = bytes_due.size();
      accepted++;
      if (op == sfb_pkg::OP_BEGIN) begin
        total = sfb_pkg::OverheadBytes + count;
        if (total > FrameLimit) begin
          bytes_due.push_back('{data: 8'h00, done: 1'b0, err: 1'b1, last: 1'b1});
          rejects++;
        end else begin
          if (frame_open) abandons++;
          running_sum = '0;
          for (int i = 0; i < 4; i++) add_data(HdrSeq[8*i +: 8], 1'b0);
          add_data(total[7:0], 1'b0);
          add_data(total[15:8], 1'b0);
          for (int i = 0; i < 4; i++) add_data(ident[8*i +: 8], (i == 3) && (count != 0));
          if (count == 0) begin
            add_checksum();
          end else begin
            frame_open = 1'b1;
            bytes_left = count;
          end
        end
      end else if (!frame_open) begin
        drops++;
      end else begin
        bytes_left--;
        add_data(pbyte, bytes_left != 0);
        if (bytes_left == 0) add_checksum();
      end
      return bytes_due.size() - size_at_entry;
    endfunction

    function void check_byte(logic [7:0] b, logic done, logic err, logic last);
      wire_byte_t want;
      checked++;
      if (bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with none expected: byte %02h done %b too_long %b last %b",
                   checked, b, done, err, last);
        return;
      end
      want = bytes_due.pop_front();
      if (b !== want.data || done !== want.done || err !== want.err || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d mismatch: expected byte %02h done %b too_long %b last %b,",
                    " got %02h %b %b %b"},
                   checked, want.data, want.done, want.err, want.last, b, done, err, last);
      end
    endfunction

    function int pending();
      return bytes_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        opcode = 1'b0;
  logic [31:0] frame_ident = '0;
  logic [7:0]  payload_count = '0;
  logic [7:0]  payload_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        frame_done;
  logic        too_long;
  logic        run_last;

  frame_byte_tracker tracker = new();
  bit quiet = 1'b0;
  int full_stalls = 0;

  serial_frame_builder #(.MAX_FRAME_BYTES(FrameLimit)) DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .opcode(opcode),
    .frame_ident(frame_ident),
    .payload_count(payload_count),
    .payload_byte(payload_byte),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .frame_done(frame_done),
    .too_long(too_long),
    .run_last(run_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d result bytes outstanding", tracker.pending());
    $display("serial_frame_builder_tb: FAIL");
    $finish;
  end

  task automatic gap(input int n);
    repeat (n) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  task automatic send_item(input sfb_pkg::op_t op, input logic [31:0] ident,
                           input logic [7:0] count, input logic [7:0] pbyte);
    if (!quiet && $urandom_range(0, 5) == 0) gap($urandom_range(1, 6));
    @(negedge clk);
    push <= 1'b1;
    opcode <= op;
    frame_ident <= ident;
    payload_count <= count;
    payload_byte <= pbyte;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    void'(tracker.take_item(op, ident, count, pbyte));
  endtask

  task automatic send_begin(input logic [7:0] count);
    send_item(sfb_pkg::OP_BEGIN, $urandom, count, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_payload();
    send_item(sfb_pkg::OP_PAYLOAD, $urandom, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic drain_all();
    @(negedge clk);
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Random traffic: mostly complete frames, plus abandoned frames, rejects and strays.
  task automatic random_traffic();
    int   pick, sent;
    logic [7:0] count;
    bit   paused;
    paused = 1'b0;
    while (tracker.accepted < ItemTarget) begin
      if (!paused && tracker.accepted >= PauseAt) begin
        paused = 1'b1;
        drain_all();
      end
      if (tracker.accepted >= QuietFrom) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 19) == 0) count = 8'(MaxPayload);
        else if ($urandom_range(0, 9) == 0) count = 8'($urandom_range(0, MaxPayload));
        else count = 8'($urandom_range(0, 6));
        send_begin(count);
        for (int i = 0; i < count; i++) begin
          if ($urandom_range(0, 39) == 0)
            send_begin(8'($urandom_range(MaxPayload + 1, 255)));
          send_payload();
        end
      end else if (pick < 80) begin
        count = 8'($urandom_range(2, 10));
        send_begin(count);
        sent = $urandom_range(0, count - 1);
        repeat (sent) send_payload();
      end else if (pick < 90) begin
        send_begin(8'($urandom_range(MaxPayload + 1, 255)));
      end else begin
        send_payload();
      end
    end
  endtask

  // Result side: random pop bursts, one long hold-off to back up the block.
  initial begin
    int idle_left;
    bit held;
    logic want;
    idle_left = 0;
    held = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!held && tracker.checked >= 150) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end
      if (idle_left > 0) begin
        idle_left--;
        want = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(0, 5);
        want = 1'b0;
      end else begin
        want = 1'b1;
      end
      pop <= want;
      @(posedge clk);
      if (pop && !empty) tracker.check_byte(out_byte, frame_done, too_long, run_last);
    end
  end

  initial begin
    int fails;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed cases
    send_item(sfb_pkg::OP_PAYLOAD, 32'h0, 8'h0, 8'hA5);          // no frame open: dropped
    send_item(sfb_pkg::OP_BEGIN, 32'h0000_0000, 8'd0, 8'h00);    // empty payload, whole frame
    send_item(sfb_pkg::OP_BEGIN, 32'hFFFF_FFFF, 8'd0, 8'hFF);
    send_item(sfb_pkg::OP_BEGIN, 32'h1234_5678, 8'd255, 8'h00);  // far over the limit
    send_item(sfb_pkg::OP_BEGIN, 32'h8765_4321, 8'(MaxPayload + 1), 8'h00);  // just over
    send_item(sfb_pkg::OP_BEGIN, 32'h1234_5678, 8'd2, 8'h00);
    send_item(sfb_pkg::OP_PAYLOAD, 32'hFFFF_FFFF, 8'hFF, 8'h00);
    send_item(sfb_pkg::OP_PAYLOAD, 32'h0, 8'h00, 8'hFF);
    send_item(sfb_pkg::OP_BEGIN, 32'hDEAD_BEEF, 8'd3, 8'h00);
    send_item(sfb_pkg::OP_PAYLOAD, 32'h0, 8'h00, 8'h80);
    send_item(sfb_pkg::OP_BEGIN, 32'hA5A5_5A5A, 8'd1, 8'h00);    // abandons the open frame
    send_item(sfb_pkg::OP_PAYLOAD, 32'h0, 8'h00, 8'h7F);
    send_item(sfb_pkg::OP_BEGIN, 32'h0F0F_F0F0, 8'd2, 8'h00);
    send_item(sfb_pkg::OP_BEGIN, 32'h0, 8'd200, 8'h00);          // rejected, open frame kept
    send_item(sfb_pkg::OP_PAYLOAD, 32'h0, 8'h00, 8'h01);
    send_item(sfb_pkg::OP_PAYLOAD, 32'h0, 8'h00, 8'hFE);
    send_item(sfb_pkg::OP_PAYLOAD, 32'h0, 8'h00, 8'h55);         // after completion: dropped
    send_item(sfb_pkg::OP_BEGIN, 32'h7FFF_FFFF, 8'd1, 8'h00);
    send_item(sfb_pkg::OP_PAYLOAD, 32'h8000_0000, 8'hFF, 8'hFF);

    random_traffic();
    drain_all();
    repeat (40) @(posedge clk);

    $display("covered %0d input transactions: %0d frames closed, %0d abandoned,",
             tracker.accepted, tracker.frames, tracker.abandons);
    $display("%0d rejected, %0d dropped; checked %0d result bytes, %0d cycles stalled on full",
             tracker.rejects, tracker.drops, tracker.checked, full_stalls);
    fails = tracker.mismatches + tracker.pending();
    if (fails == 0) begin
      $display("serial_frame_builder_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", tracker.mismatches, tracker.pending());
      $display("serial_frame_builder_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== serial_frame_builder.f =====
rtl/core/sfb_pkg.sv
rtl/core/sfb_front.sv
rtl/core/sfb_queue.sv
rtl/core/sfb_back.sv
rtl/core/serial_frame_builder.sv
test/serial_frame_builder_tb.sv
